### rtl/indexed_block_file_store_assert.svh
// Assertion macros shared by the file store modules.
// Both forms sample on clk; the first one is muted while rst_n is low.
`ifndef INDEXED_BLOCK_FILE_STORE_ASSERT_SVH
`define INDEXED_BLOCK_FILE_STORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define IBFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IBFS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IBFS_ASSERT(label, prop, msg)
`define IBFS_ASSERT_RST(label, prop, msg)
`endif
`endif

### rtl/ibfs_pkg.sv
package ibfs_pkg;

    localparam int unsigned NUM_BLOCKS_DEF   = 256;
    localparam int unsigned MAX_ENTRIES_DEF  = 64;
    localparam int unsigned MAX_FILE_LEN_DEF = 64;
    localparam int unsigned KEY_WIDTH_DEF    = 32;

    localparam int FUNC_W   = 3;
    localparam int KEY_IN_W = 32;
    localparam int LEN_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int STAT_W   = 3;
    localparam int BNUM_W   = 8;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic [1:0]        mode_t;

    localparam func_t FN_CREATE = 3'd0;
    localparam func_t FN_READ   = 3'd1;
    localparam func_t FN_UPDATE = 3'd2;
    localparam func_t FN_DELETE = 3'd3;
    localparam func_t FN_DATA   = 3'd4;

    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_FULL       = 3'd1;
    localparam status_t ST_DUP        = 3'd2;
    localparam status_t ST_NOSPACE    = 3'd3;
    localparam status_t ST_NOTFOUND   = 3'd4;
    localparam status_t ST_TOOLONG    = 3'd5;
    localparam status_t ST_BADLEN     = 3'd6;
    localparam status_t ST_UNEXPECTED = 3'd7;

    localparam mode_t MODE_NONE   = 2'd0;
    localparam mode_t MODE_CREATE = 2'd1;
    localparam mode_t MODE_UPDATE = 2'd2;

    typedef struct packed {
        logic    latch;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    n_clr;
        logic    n_inc_free;
        logic    scan_clr;
        logic    clr_wr;
        logic    rd_ent;
        logic    eval_ent;
        logic    rd_used;
        logic    alloc;
        logic    rd_idx_scan;
        logic    rd_idx_pend;
        logic    rd_content;
        logic    blk_cap;
        logic    wr_byte;
        logic    zero_blk;
        logic    free_blk;
        logic    ent_wr;
        logic    ent_del;
        logic    pend_clr;
        logic    pend_create;
        logic    pend_update;
        logic    pend_adv;
        logic    emit;
        logic    emit_data;
        status_t code;
    } ibfs_cmd_t;

    typedef struct packed {
        func_t func;
        logic  pend_active;
        logic  bad_len;
        logic  too_long;
        logic  len_zero;
        logic  slot_found;
        logic  match_found;
        logic  n_full;
        logic  blk_free;
        logic  cnt_last_blk;
        logic  cnt_last_ent;
        logic  cnt_last_size;
        logic  cnt_last_clr;
    } ibfs_stat_t;

endpackage

### rtl/indexed_block_file_store.sv
// File store with one-byte disk blocks and indexed allocation. Pulse start with
// busy low to transfer a command (create, read, update, delete) or a data byte
// for a pending create or update; inputs are sampled on that edge. Every item
// yields one result strobed on valid for a single cycle, except a read of an
// existing file, which yields one result per block with last on the final one.
// Results cannot be held off: capture each one on the cycle valid is high.
// After reset the block runs a clearing pass over max(NUM_BLOCKS, MAX_ENTRIES)
// entries with busy high. Items are handled one at a time by one sequential
// scan engine whose memories each have one write port and one registered read
// port: a data byte for a pending fill is written to its block; a stray data
// byte, an unknown code or a create with a bad length is answered at decode;
// read, update and delete first scan the file table (a missing file ends
// there), then a read visits each file block and update and delete clear each
// block; a create does the same table scan, then counts free blocks and
// claims them. Each result appears the cycle after the one that produced
// it.
module indexed_block_file_store
    import ibfs_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS   = NUM_BLOCKS_DEF,
    parameter int unsigned MAX_ENTRIES  = MAX_ENTRIES_DEF,
    parameter int unsigned MAX_FILE_LEN = MAX_FILE_LEN_DEF,
    parameter int unsigned KEY_WIDTH    = KEY_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [KEY_IN_W-1:0] file_key,
    input  logic [LEN_W-1:0]    length,
    input  logic [BYTE_W-1:0]   data_byte,
    output logic                valid,
    output logic [STAT_W-1:0]   status,
    output logic [BNUM_W-1:0]   block_number,
    output logic [BYTE_W-1:0]   block_byte,
    output logic                last
);

    // Command and status bundles between sequencer and datapath
    ibfs_cmd_t  cmd;
    ibfs_stat_t stat;

    // Sequencer: decode each transfer and step the scans
    ibfs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Datapath: block map, contents, file table, index memory, result register
    ibfs_dp #(
        .NUM_BLOCKS   (NUM_BLOCKS),
        .MAX_ENTRIES  (MAX_ENTRIES),
        .MAX_FILE_LEN (MAX_FILE_LEN),
        .KEY_WIDTH    (KEY_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .func         (func),
        .file_key     (file_key),
        .length       (length),
        .data_byte    (data_byte),
        .valid        (valid),
        .status       (status),
        .block_number (block_number),
        .block_byte   (block_byte),
        .last         (last)
    );

endmodule

### rtl/ibfs_dp.sv
`include "indexed_block_file_store_assert.svh"
module ibfs_dp
    import ibfs_pkg::*;
#(
    parameter int unsigned NUM_BLOCKS   = NUM_BLOCKS_DEF,
    parameter int unsigned MAX_ENTRIES  = MAX_ENTRIES_DEF,
    parameter int unsigned MAX_FILE_LEN = MAX_FILE_LEN_DEF,
    parameter int unsigned KEY_WIDTH    = KEY_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ibfs_cmd_t           cmd,
    output ibfs_stat_t          stat,
    input  logic [FUNC_W-1:0]   func,
    input  logic [KEY_IN_W-1:0] file_key,
    input  logic [LEN_W-1:0]    length,
    input  logic [BYTE_W-1:0]   data_byte,
    output logic                valid,
    output logic [STAT_W-1:0]   status,
    output logic [BNUM_W-1:0]   block_number,
    output logic [BYTE_W-1:0]   block_byte,
    output logic                last
);

    localparam int unsigned BW        = $clog2(NUM_BLOCKS);
    localparam int unsigned EW        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned LW        = $clog2(MAX_FILE_LEN + 1);
    localparam int unsigned IDX_DEPTH = MAX_ENTRIES * MAX_FILE_LEN;
    localparam int unsigned IAW       = (IDX_DEPTH > 1) ? $clog2(IDX_DEPTH) : 1;
    localparam int unsigned CLR_N     = (NUM_BLOCKS > MAX_ENTRIES) ? NUM_BLOCKS : MAX_ENTRIES;
    localparam int unsigned CNT_MAX   = (CLR_N > MAX_FILE_LEN) ? CLR_N : MAX_FILE_LEN;
    localparam int unsigned CW        = $clog2(CNT_MAX);

    logic                 used_mem    [NUM_BLOCKS];
    logic [BYTE_W-1:0]    content_mem [NUM_BLOCKS];
    logic                 valid_mem   [MAX_ENTRIES];
    logic [KEY_WIDTH-1:0] key_mem     [MAX_ENTRIES];
    logic [LW-1:0]        size_mem    [MAX_ENTRIES];
    logic [BW-1:0]        index_mem   [IDX_DEPTH];

    logic [CW-1:0]        cnt_reg;
    logic [LW-1:0]        n_reg;
    logic                 slot_found_reg;
    logic                 match_found_reg;
    logic [EW-1:0]        slot_reg;
    logic [EW-1:0]        match_reg;
    logic [LW-1:0]        size_reg;
    logic [BW-1:0]        blk_reg;
    mode_t                pend_mode_reg;
    logic [EW-1:0]        pend_entry_reg;
    logic [LW-1:0]        pend_count_reg;
    logic [LW-1:0]        pend_total_reg;
    func_t                func_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [BYTE_W-1:0]    byte_reg;

    logic                 used_rdata_reg;
    logic [BYTE_W-1:0]    content_rdata_reg;
    logic                 ent_valid_rdata_reg;
    logic [KEY_WIDTH-1:0] ent_key_rdata_reg;
    logic [LW-1:0]        ent_size_rdata_reg;
    logic [BW-1:0]        idx_rdata_reg;

    logic                 valid_reg;
    status_t              status_reg;
    logic [BNUM_W-1:0]    bnum_reg;
    logic [BYTE_W-1:0]    bbyte_reg;
    logic                 last_reg;

    logic [IAW-1:0]       idx_scan_addr;
    logic [IAW-1:0]       idx_pend_addr;
    logic [IAW-1:0]       idx_alloc_addr;
    logic [IAW-1:0]       idx_raddr;
    logic [BW-1:0]        used_waddr;
    logic [BW-1:0]        content_waddr;
    logic [EW-1:0]        ent_waddr;
    logic                 used_we;
    logic                 content_we;
    logic                 ent_we;
    logic                 cnt_last_size;
    logic [LW-1:0]        pend_count_inc;

    assign idx_scan_addr  = IAW'(int'(match_reg) * int'(MAX_FILE_LEN) + int'(cnt_reg));
    assign idx_pend_addr  = IAW'(int'(pend_entry_reg) * int'(MAX_FILE_LEN)
                                 + int'(pend_count_reg));
    assign idx_alloc_addr = IAW'(int'(slot_reg) * int'(MAX_FILE_LEN) + int'(n_reg));
    assign idx_raddr      = cmd.rd_idx_pend ? idx_pend_addr : idx_scan_addr;

    assign used_we       = cmd.clr_wr | cmd.alloc | cmd.free_blk;
    assign used_waddr    = cmd.free_blk ? idx_rdata_reg : cnt_reg[BW-1:0];
    assign content_we    = cmd.clr_wr | cmd.wr_byte | cmd.zero_blk;
    assign content_waddr = cmd.clr_wr ? cnt_reg[BW-1:0] : idx_rdata_reg;
    assign ent_we        = cmd.clr_wr | cmd.ent_wr | cmd.ent_del;
    assign ent_waddr     = cmd.clr_wr ? cnt_reg[EW-1:0] :
                           (cmd.ent_wr ? slot_reg : match_reg);

    assign cnt_last_size  = ((CW+1)'(cnt_reg) + (CW+1)'(1)) == (CW+1)'(size_reg);
    assign pend_count_inc = pend_count_reg + LW'(1);

    // Memories: one write and one registered read per cycle each
    always_ff @(posedge clk)
    begin
        if (used_we)
            used_mem[used_waddr] <= cmd.alloc;
        if (cmd.rd_used)
            used_rdata_reg <= used_mem[cnt_reg[BW-1:0]];
        if (content_we)
            content_mem[content_waddr] <= cmd.wr_byte ? byte_reg : '0;
        if (cmd.rd_content)
            content_rdata_reg <= content_mem[idx_rdata_reg];
        if (ent_we)
            valid_mem[ent_waddr] <= cmd.ent_wr;
        if (cmd.ent_wr)
        begin
            key_mem[slot_reg]  <= key_reg;
            size_mem[slot_reg] <= LW'(len_reg);
        end
        if (cmd.rd_ent)
        begin
            ent_valid_rdata_reg <= valid_mem[cnt_reg[EW-1:0]];
            ent_key_rdata_reg   <= key_mem[cnt_reg[EW-1:0]];
            ent_size_rdata_reg  <= size_mem[cnt_reg[EW-1:0]];
        end
        if (cmd.alloc)
            index_mem[idx_alloc_addr] <= cnt_reg[BW-1:0];
        if (cmd.rd_idx_scan || cmd.rd_idx_pend)
            idx_rdata_reg <= index_mem[idx_raddr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg <= func;
            key_reg  <= KEY_WIDTH'(file_key);
            len_reg  <= length;
            byte_reg <= data_byte;
        end
        if (cmd.eval_ent && ent_valid_rdata_reg && ent_key_rdata_reg == key_reg)
        begin
            match_reg <= cnt_reg[EW-1:0];
            size_reg  <= ent_size_rdata_reg;
        end
        if (cmd.eval_ent && !ent_valid_rdata_reg && !slot_found_reg)
            slot_reg <= cnt_reg[EW-1:0];
        if (cmd.blk_cap)
            blk_reg <= idx_rdata_reg;
        if (cmd.emit)
        begin
            status_reg <= cmd.code;
            bnum_reg   <= cmd.emit_data ? BNUM_W'(blk_reg) : '0;
            bbyte_reg  <= cmd.emit_data ? content_rdata_reg : '0;
            last_reg   <= cmd.emit_data ? cnt_last_size : 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            n_reg           <= '0;
            slot_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
            pend_mode_reg   <= MODE_NONE;
            pend_entry_reg  <= '0;
            pend_count_reg  <= '0;
            pend_total_reg  <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + CW'(1);
            if (cmd.n_clr)
                n_reg <= '0;
            else if (cmd.alloc || (cmd.n_inc_free && !used_rdata_reg))
                n_reg <= n_reg + LW'(1);
            if (cmd.scan_clr)
            begin
                slot_found_reg  <= 1'b0;
                match_found_reg <= 1'b0;
            end
            else if (cmd.eval_ent)
            begin
                if (ent_valid_rdata_reg && ent_key_rdata_reg == key_reg)
                    match_found_reg <= 1'b1;
                if (!ent_valid_rdata_reg)
                    slot_found_reg <= 1'b1;
            end
            if (cmd.pend_clr)
                pend_mode_reg <= MODE_NONE;
            else if (cmd.pend_create || cmd.pend_update)
            begin
                pend_mode_reg  <= cmd.pend_create ? MODE_CREATE : MODE_UPDATE;
                pend_entry_reg <= cmd.pend_create ? slot_reg : match_reg;
                pend_count_reg <= '0;
                pend_total_reg <= LW'(len_reg);
            end
            else if (cmd.pend_adv)
            begin
                pend_count_reg <= pend_count_inc;
                if (pend_count_inc == pend_total_reg)
                    pend_mode_reg <= MODE_NONE;
            end
        end
    end

    always_comb
    begin
        stat.func          = func_reg;
        stat.pend_active   = pend_mode_reg != MODE_NONE;
        stat.bad_len       = (len_reg == '0) || (len_reg > LEN_W'(MAX_FILE_LEN));
        stat.too_long      = len_reg > LEN_W'(size_reg);
        stat.len_zero      = len_reg == '0;
        stat.slot_found    = slot_found_reg;
        stat.match_found   = match_found_reg;
        stat.n_full        = LEN_W'(n_reg) == len_reg;
        stat.blk_free      = !used_rdata_reg;
        stat.cnt_last_blk  = cnt_reg == CW'(NUM_BLOCKS - 1);
        stat.cnt_last_ent  = cnt_reg == CW'(MAX_ENTRIES - 1);
        stat.cnt_last_size = cnt_last_size;
        stat.cnt_last_clr  = cnt_reg == CW'(CLR_N - 1);
    end

    assign valid        = valid_reg;
    assign status       = status_reg;
    assign block_number = bnum_reg;
    assign block_byte   = bbyte_reg;
    assign last         = last_reg;

    `IBFS_ASSERT(a_pend_in_range, pend_mode_reg != MODE_NONE |-> pend_count_reg < pend_total_reg, "pending count past total")
    `IBFS_ASSERT(a_strobe_gap, valid_reg |=> !valid_reg, "results on adjacent cycles")
    `IBFS_ASSERT(a_del_matched, cmd.ent_del |-> match_found_reg, "delete without a matching entry")

endmodule

### rtl/ibfs_ctrl.sv
`include "indexed_block_file_store_assert.svh"
module ibfs_ctrl
    import ibfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  ibfs_stat_t stat,
    output ibfs_cmd_t  cmd,
    output logic       busy
);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DEC   = 5'd2;
    localparam logic [4:0] S_DWR   = 5'd3;
    localparam logic [4:0] S_ERD   = 5'd4;
    localparam logic [4:0] S_EEV   = 5'd5;
    localparam logic [4:0] S_EDONE = 5'd6;
    localparam logic [4:0] S_CRD   = 5'd7;
    localparam logic [4:0] S_CEV   = 5'd8;
    localparam logic [4:0] S_CCHK  = 5'd9;
    localparam logic [4:0] S_ARD   = 5'd10;
    localparam logic [4:0] S_AEV   = 5'd11;
    localparam logic [4:0] S_AFIN  = 5'd12;
    localparam logic [4:0] S_IRD   = 5'd13;
    localparam logic [4:0] S_IUSE  = 5'd14;
    localparam logic [4:0] S_REMIT = 5'd15;
    localparam logic [4:0] S_FIN   = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.cnt_last_clr)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                    cmd.cnt_inc = 1'b1;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (stat.func) inside
                    FN_DATA:
                    begin
                        if (!stat.pend_active)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.code   = ST_UNEXPECTED;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_idx_pend = 1'b1;
                            state_next      = S_DWR;
                        end
                    end
                    FN_CREATE, FN_READ, FN_UPDATE, FN_DELETE:
                    begin
                        cmd.pend_clr = 1'b1;
                        if (stat.func == FN_CREATE && stat.bad_len)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.code   = ST_BADLEN;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.cnt_clr  = 1'b1;
                            cmd.scan_clr = 1'b1;
                            state_next   = S_ERD;
                        end
                    end
                    default:
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = ST_UNEXPECTED;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DWR:
            begin
                cmd.wr_byte  = 1'b1;
                cmd.pend_adv = 1'b1;
                cmd.emit     = 1'b1;
                cmd.code     = ST_OK;
                state_next   = S_IDLE;
            end
            S_ERD:
            begin
                cmd.rd_ent = 1'b1;
                state_next = S_EEV;
            end
            S_EEV:
            begin
                cmd.eval_ent = 1'b1;
                if (stat.cnt_last_ent)
                    state_next = S_EDONE;
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_ERD;
                end
            end
            S_EDONE:
            begin
                if (stat.func == FN_CREATE)
                begin
                    if (!stat.slot_found)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = ST_FULL;
                        state_next = S_IDLE;
                    end
                    else if (stat.match_found)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = ST_DUP;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.cnt_clr = 1'b1;
                        cmd.n_clr   = 1'b1;
                        state_next  = S_CRD;
                    end
                end
                else if (!stat.match_found)
                begin
                    cmd.emit   = 1'b1;
                    cmd.code   = ST_NOTFOUND;
                    state_next = S_IDLE;
                end
                else if (stat.func == FN_UPDATE && stat.too_long)
                begin
                    cmd.emit   = 1'b1;
                    cmd.code   = ST_TOOLONG;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_IRD;
                end
            end
            S_CRD:
            begin
                if (stat.n_full)
                begin
                    cmd.cnt_clr = 1'b1;
                    cmd.n_clr   = 1'b1;
                    state_next  = S_ARD;
                end
                else
                begin
                    cmd.rd_used = 1'b1;
                    state_next  = S_CEV;
                end
            end
            S_CEV:
            begin
                cmd.n_inc_free = 1'b1;
                if (stat.cnt_last_blk)
                    state_next = S_CCHK;
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_CRD;
                end
            end
            S_CCHK:
            begin
                if (stat.n_full)
                begin
                    cmd.cnt_clr = 1'b1;
                    cmd.n_clr   = 1'b1;
                    state_next  = S_ARD;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    cmd.code   = ST_NOSPACE;
                    state_next = S_IDLE;
                end
            end
            S_ARD:
            begin
                if (stat.n_full)
                    state_next = S_AFIN;
                else
                begin
                    cmd.rd_used = 1'b1;
                    state_next  = S_AEV;
                end
            end
            S_AEV:
            begin
                cmd.alloc   = stat.blk_free;
                cmd.cnt_inc = 1'b1;
                state_next  = S_ARD;
            end
            S_AFIN:
            begin
                cmd.ent_wr      = 1'b1;
                cmd.pend_create = 1'b1;
                cmd.emit        = 1'b1;
                cmd.code        = ST_OK;
                state_next      = S_IDLE;
            end
            S_IRD:
            begin
                cmd.rd_idx_scan = 1'b1;
                state_next      = S_IUSE;
            end
            S_IUSE:
            begin
                if (stat.func == FN_READ)
                begin
                    cmd.rd_content = 1'b1;
                    cmd.blk_cap    = 1'b1;
                    state_next     = S_REMIT;
                end
                else
                begin
                    cmd.zero_blk = 1'b1;
                    cmd.free_blk = stat.func == FN_DELETE;
                    if (stat.cnt_last_size)
                        state_next = S_FIN;
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = S_IRD;
                    end
                end
            end
            S_REMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_data = 1'b1;
                cmd.code      = ST_OK;
                if (stat.cnt_last_size)
                    state_next = S_IDLE;
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_IRD;
                end
            end
            S_FIN:
            begin
                cmd.pend_update = stat.func == FN_UPDATE && !stat.len_zero;
                cmd.ent_del     = stat.func == FN_DELETE;
                cmd.emit        = 1'b1;
                cmd.code        = ST_OK;
                state_next      = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = state_reg != S_IDLE;

    `IBFS_ASSERT(a_no_overalloc, cmd.alloc |-> !stat.n_full, "block taken beyond requested length")
    `IBFS_ASSERT(a_emit_busy, cmd.emit |-> busy, "result issued while idle")
    `IBFS_ASSERT_RST(a_busy_in_reset, !rst_n |-> busy, "ready during reset")

endmodule

### tb/indexed_block_file_store_test.sv
`timescale 1ns / 1ps

module indexed_block_file_store_test;
    import ibfs_pkg::*;

    localparam int NBLK   = 256;
    localparam int NENT   = 64;
    localparam int MAXLEN = 64;
    localparam int TAIL   = 60;    // last items go out back to back

    // One command or data byte as the driver presents it.
    typedef struct {
        func_t           fn;
        logic [31:0]     key;
        logic [6:0]      len;
        logic [7:0]      dbyte;
        bit              drain_first;   // wait for every result before this one
    } store_cmd_t;

    // One result as the block should strobe it.
    typedef struct {
        status_t     st;
        logic [7:0]  bnum;
        logic [7:0]  bbyte;
        logic        fin;
    } store_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  func;
    logic [31:0] file_key;
    logic [6:0]  length;
    logic [7:0]  data_byte;
    logic        valid;
    logic [2:0]  status;
    logic [7:0]  block_number;
    logic [7:0]  block_byte;
    logic        last;

    indexed_block_file_store u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .file_key     (file_key),
        .length       (length),
        .data_byte    (data_byte),
        .valid        (valid),
        .status       (status),
        .block_number (block_number),
        .block_byte   (block_byte),
        .last         (last)
    );

    // Shadow copy of the store contents.
    bit          blk_taken [NBLK];
    logic [7:0]  blk_data  [NBLK];
    bit          file_live [NENT];
    logic [31:0] file_name [NENT];
    int          file_len  [NENT];
    int          file_map  [NENT][MAXLEN];
    mode_t       fill_mode;
    int          fill_file;
    int          fill_done;
    int          fill_total;

    store_cmd_t    cmd_q[$];
    store_result_t expected_results[$];
    logic [31:0]   key_pool[80];

    int  issued_cnt   = 0;
    int  accepted_cnt = 0;
    int  idle_left    = 0;
    int  errors       = 0;
    bit  gen_done     = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void push_result(status_t st, logic [7:0] bn, logic [7:0] bb,
                                        logic fin);
        store_result_t r;
        r.st = st; r.bnum = bn; r.bbyte = bb; r.fin = fin;
        expected_results.push_back(r);
    endfunction

    function automatic int lookup_file(logic [31:0] k);
        for (int e = 0; e < NENT; e++)
            if (file_live[e] && file_name[e] == k)
                return e;
        return -1;
    endfunction

    // Advance the shadow store by one accepted transfer and queue its results.
    function automatic void predict_file_op(store_cmd_t c);
        int slot;
        int e;
        int n;
        int blk;
        if (c.fn > FN_DATA)
        begin
            push_result(ST_UNEXPECTED, 8'd0, 8'd0, 1'b1);
            return;
        end
        if (c.fn == FN_DATA)
        begin
            if (fill_mode == MODE_NONE)
            begin
                push_result(ST_UNEXPECTED, 8'd0, 8'd0, 1'b1);
                return;
            end
            if (fill_done < MAXLEN)
                blk_data[file_map[fill_file][fill_done]] = c.dbyte;
            fill_done++;
            if (fill_done >= fill_total)
                fill_mode = MODE_NONE;
            push_result(ST_OK, 8'd0, 8'd0, 1'b1);
            return;
        end
        // any header ends a pending fill
        fill_mode = MODE_NONE;
        if (c.fn == FN_CREATE)
        begin
            slot = -1;
            if (c.len == 0 || c.len > MAXLEN)
            begin
                push_result(ST_BADLEN, 8'd0, 8'd0, 1'b1);
                return;
            end
            for (int i = 0; i < NENT; i++)
                if (!file_live[i] && slot < 0)
                    slot = i;
            if (slot < 0)
            begin
                push_result(ST_FULL, 8'd0, 8'd0, 1'b1);
                return;
            end
            if (lookup_file(c.key) >= 0)
            begin
                push_result(ST_DUP, 8'd0, 8'd0, 1'b1);
                return;
            end
            n = 0;
            for (int b = 0; b < NBLK; b++)
                if (!blk_taken[b])
                    n++;
            if (n < c.len)
            begin
                push_result(ST_NOSPACE, 8'd0, 8'd0, 1'b1);
                return;
            end
            // claim the lowest free blocks
            n = 0;
            for (int b = 0; b < NBLK && n < c.len; b++)
                if (!blk_taken[b])
                begin
                    blk_taken[b] = 1;
                    file_map[slot][n] = b;
                    n++;
                end
            file_live[slot] = 1;
            file_name[slot] = c.key;
            file_len[slot]  = c.len;
            fill_mode  = MODE_CREATE;
            fill_file  = slot;
            fill_done  = 0;
            fill_total = c.len;
            push_result(ST_OK, 8'd0, 8'd0, 1'b1);
            return;
        end
        e = lookup_file(c.key);
        if (e < 0)
        begin
            push_result(ST_NOTFOUND, 8'd0, 8'd0, 1'b1);
            return;
        end
        if (c.fn == FN_READ)
        begin
            for (int j = 0; j < file_len[e]; j++)
            begin
                blk = file_map[e][j];
                push_result(ST_OK, blk[7:0], blk_data[blk], j + 1 == file_len[e]);
            end
            return;
        end
        if (c.fn == FN_UPDATE)
        begin
            if (c.len > file_len[e])
            begin
                push_result(ST_TOOLONG, 8'd0, 8'd0, 1'b1);
                return;
            end
            for (int j = 0; j < file_len[e]; j++)
                blk_data[file_map[e][j]] = 8'd0;
            if (c.len > 0)
            begin
                fill_mode  = MODE_UPDATE;
                fill_file  = e;
                fill_done  = 0;
                fill_total = c.len;
            end
            push_result(ST_OK, 8'd0, 8'd0, 1'b1);
            return;
        end
        // delete: clear and free every block of the file
        for (int j = 0; j < file_len[e]; j++)
        begin
            blk_data[file_map[e][j]]  = 8'd0;
            blk_taken[file_map[e][j]] = 0;
        end
        file_live[e] = 0;
        push_result(ST_OK, 8'd0, 8'd0, 1'b1);
    endfunction

    task automatic add_cmd(func_t fn, logic [31:0] k, logic [6:0] ln, logic [7:0] db);
        store_cmd_t c;
        c.fn = fn; c.key = k; c.len = ln; c.dbyte = db; c.drain_first = 0;
        cmd_q.push_back(c);
    endtask

    task automatic add_data(int count);
        for (int i = 0; i < count; i++)
            add_cmd(FN_DATA, $urandom, 7'($urandom), 8'($urandom));
    endtask

    // Driver: change inputs on the falling edge, hold each item until accepted.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && accepted_cnt != issued_cnt)
        begin
            // hold until the block takes it
        end
        else if (idle_left > 0)
        begin
            start     <= 1'b0;
            idle_left <= idle_left - 1;
        end
        else if (cmd_q.size() > 0 && cmd_q[0].drain_first && expected_results.size() > 0)
        begin
            start <= 1'b0;
        end
        else if (cmd_q.size() > 0)
        begin
            store_cmd_t c;
            c = cmd_q.pop_front();
            func      <= c.fn;
            file_key  <= c.key;
            length    <= c.len;
            data_byte <= c.dbyte;
            start     <= 1'b1;
            issued_cnt <= issued_cnt + 1;
            if (cmd_q.size() > TAIL && $urandom_range(3) == 0)
                idle_left <= $urandom_range(7, 1);
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // Monitor: sample on the rising edge; check strobed results, then predict
    // from any transfer taken on this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (valid)
            begin
                store_result_t x;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: status=%0d bn=%0d byte=%0d last=%0d",
                                 status, block_number, block_byte, last);
                end
                else
                begin
                    x = expected_results.pop_front();
                    if (status !== x.st || block_number !== x.bnum ||
                        block_byte !== x.bbyte || last !== x.fin)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp st=%0d bn=%0d byte=%0d last=%0d,",
                                      " got st=%0d bn=%0d byte=%0d last=%0d"},
                                     x.st, x.bnum, x.bbyte, x.fin,
                                     status, block_number, block_byte, last);
                    end
                end
            end
            if (start && !busy)
            begin
                store_cmd_t c;
                c.fn = func; c.key = file_key; c.len = length; c.dbyte = data_byte;
                c.drain_first = 0;
                predict_file_op(c);
                accepted_cnt <= accepted_cnt + 1;
            end
        end
    end

    // Stimulus.
    initial
    begin
        int op;
        int ln;
        int nd;
        bit drain_set;
        logic [31:0] k;
        logic [31:0] kd [4];
        fill_mode = MODE_NONE;
        fill_file = 0; fill_done = 0; fill_total = 0;
        drain_set = 0;
        for (int b = 0; b < NBLK; b++)
        begin
            blk_taken[b] = 0;
            blk_data[b]  = 8'd0;
        end
        for (int e = 0; e < NENT; e++)
            file_live[e] = 0;
        for (int i = 0; i < 80; i++)
            key_pool[i] = $urandom;
        for (int i = 0; i < 4; i++)
            kd[i] = key_pool[i];

        // directed part
        add_cmd(FN_DATA, 32'd0, 7'd0, 8'hFF);            // stray data
        add_cmd(func_t'(5), $urandom, 7'($urandom), 8'($urandom));
        add_cmd(func_t'(6), $urandom, 7'($urandom), 8'($urandom));
        add_cmd(func_t'(7), 32'hFFFF_FFFF, 7'h7F, 8'hFF);
        add_cmd(FN_CREATE, kd[0], 7'd0, 8'd0);           // zero length
        add_cmd(FN_CREATE, kd[0], 7'd65, 8'd0);          // just over the limit
        add_cmd(FN_CREATE, kd[0], 7'd127, 8'd0);
        add_cmd(FN_CREATE, kd[0], 7'd64, 8'd0);
        add_cmd(FN_DATA, 32'd0, 7'd0, 8'h00);
        add_cmd(FN_DATA, 32'd0, 7'd0, 8'hFF);
        add_data(62);
        add_cmd(FN_READ, kd[0], 7'd0, 8'd0);
        add_cmd(FN_CREATE, kd[0], 7'd1, 8'd0);           // duplicate key
        add_cmd(FN_CREATE, kd[1], 7'd64, 8'd0);
        add_data(5);                                     // cut short by next header
        add_cmd(FN_CREATE, kd[2], 7'd64, 8'd0);
        add_cmd(FN_CREATE, kd[3], 7'd64, 8'd0);
        add_cmd(FN_CREATE, 32'hFFFF_FFFF, 7'd1, 8'd0);   // store is out of blocks
        add_cmd(FN_UPDATE, kd[0], 7'd65, 8'd0);          // longer than the file
        add_cmd(FN_UPDATE, kd[0], 7'd0, 8'd0);           // clear only
        add_cmd(FN_UPDATE, kd[1], 7'd3, 8'd0);
        add_data(2);
        add_cmd(FN_READ, kd[1], 7'd0, 8'd0);
        add_cmd(FN_READ, 32'd0, 7'd0, 8'd0);             // unknown keys
        add_cmd(FN_UPDATE, 32'd0, 7'd1, 8'd0);
        add_cmd(FN_DELETE, 32'd0, 7'd0, 8'd0);
        for (int i = 0; i < 4; i++)
            add_cmd(FN_DELETE, kd[i], 7'd0, 8'd0);
        add_cmd(FN_CREATE, 32'hFFFF_FFFF, 7'd1, 8'd0);
        add_data(1);
        add_cmd(FN_READ, 32'hFFFF_FFFF, 7'd0, 8'd0);
        add_cmd(FN_DELETE, 32'hFFFF_FFFF, 7'd0, 8'd0);

        // random part: mostly well-formed create/update sequences with data
        while (cmd_q.size() < 420)
        begin
            if (!drain_set && cmd_q.size() > 200)
            begin
                cmd_q[cmd_q.size() - 1].drain_first = 1;
                drain_set = 1;
            end
            k = key_pool[$urandom_range(79)];
            op = $urandom_range(99);
            if (op < 40)
            begin
                ln = $urandom_range(19);
                if (ln < 17)
                    ln = $urandom_range(4, 1);
                else if (ln == 17)
                    ln = 64;
                else if (ln == 18)
                    ln = 0;
                else
                    ln = $urandom_range(127, 65);
                add_cmd(FN_CREATE, k, 7'(ln), 8'($urandom));
                nd = ($urandom_range(4) == 0) ? $urandom_range(ln) : ln;
                if (ln > MAXLEN)
                    nd = 0;
                add_data(nd);
            end
            else if (op < 60)
            begin
                add_cmd(FN_READ, k, 7'($urandom), 8'($urandom));
            end
            else if (op < 75)
            begin
                ln = ($urandom_range(9) == 0) ? $urandom_range(127, 65) : $urandom_range(5);
                add_cmd(FN_UPDATE, k, 7'(ln), 8'($urandom));
                if (ln <= MAXLEN)
                    add_data(($urandom_range(3) == 0) ? $urandom_range(ln) : ln);
            end
            else if (op < 90)
            begin
                add_cmd(FN_DELETE, k, 7'($urandom), 8'($urandom));
            end
            else if (op < 95)
            begin
                add_data(1);
            end
            else
            begin
                add_cmd(func_t'($urandom_range(7, 5)), $urandom, 7'($urandom), 8'($urandom));
            end
        end
        gen_done = 1;
    end

    // Reset, end of run and report.
    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        func      = FN_DATA;
        file_key  = 32'd0;
        length    = 7'd0;
        data_byte = 8'd0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        wait (gen_done);
        while (cmd_q.size() > 0 || accepted_cnt != issued_cnt || start)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
